// ----- hdl/psd_pkg.sv -----
// shared types and constants of the pointer shake detector
`timescale 1ns / 1ps
`default_nettype none

package psd_pkg;

    // field widths of one input word and of the configuration registers
    localparam int TIME_W = 32;
    localparam int POS_W  = 16;
    localparam int STEP_W = 17;
    localparam int WIN_W  = 24;
    localparam int SWING_W = 12;
    localparam int THR_W  = 4;

    // operand and accumulator widths of the shared multiply-accumulate unit
    localparam int OPND_W = 18;
    localparam int ACC_W  = 36;

    // squared step length that counts as motion
    localparam logic signed [ACC_W-1:0] MOTION_MIN_SQ = 36'sd4;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_US  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_THRESH = 2'd2;

    // register reset values
    localparam logic [WIN_W-1:0]   WINDOW_US_RST  = 24'd600000;
    localparam logic [SWING_W-1:0] MIN_SWING_RST  = 12'd30;
    localparam logic [THR_W-1:0]   REV_THRESH_RST = 4'd4;

    // input kind codes
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // control of the multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic acc_clr;
    } mac_ctrl_t;

    // sequencer states
    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_SQX    = 12'b0000_0000_0010,
        ST_SQY    = 12'b0000_0000_0100,
        ST_DOTX   = 12'b0000_0000_1000,
        ST_DOTY   = 12'b0000_0001_0000,
        ST_DOTCHK = 12'b0000_0010_0000,
        ST_EY     = 12'b0000_0100_0000,
        ST_NEED   = 12'b0000_1000_0000,
        ST_SWING  = 12'b0001_0000_0000,
        ST_PRD    = 12'b0010_0000_0000,
        ST_PCHK   = 12'b0100_0000_0000,
        ST_OUT    = 12'b1000_0000_0000
    } seq_state_t;

endpackage

`default_nettype wire

// ----- hdl/psd_mac.sv -----
// shared signed multiply-accumulate unit
`timescale 1ns / 1ps
`default_nettype none

module psd_mac (
    input  wire logic                                  aclk,
    input  wire psd_pkg::mac_ctrl_t                    ctrl,
    input  wire logic signed [psd_pkg::OPND_W-1:0]     op_a,
    input  wire logic signed [psd_pkg::OPND_W-1:0]     op_b,
    output logic signed [psd_pkg::ACC_W-1:0]           acc
);
    import psd_pkg::*;

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] prod;

    always_comb begin
        prod = op_a * op_b;
        acc_next = (ctrl.acc_clr ? '0 : acc_reg) + prod;
    end

    always_ff @(posedge aclk) begin
        if (ctrl.en) begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ----- hdl/psd_ring.sv -----
// timestamp store of recorded reversals, one write and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module psd_ring #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic                         aclk,
    input  wire logic                         wr_en,
    input  wire logic [AW-1:0]                wr_addr,
    input  wire logic [psd_pkg::TIME_W-1:0]   wr_data,
    input  wire logic                         rd_en,
    input  wire logic [AW-1:0]                rd_addr,
    output logic [psd_pkg::TIME_W-1:0]        rd_data
);
    import psd_pkg::*;

    logic [TIME_W-1:0] mem [DEPTH];
    logic [TIME_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- hdl/pointer_shake_detector.sv -----
// top level of the pointer shake detector: sequencer, state and handshakes
`timescale 1ns / 1ps
`default_nettype none

// Pointer shake detector. Each input word is a pointer sample (tuser = 0) or a
// clear command (tuser = 1) and yields exactly one result word with the shake
// flag and the number of recent reversals. A sample runs through a small
// sequencer that drives one 18x18 signed multiply-accumulate unit for the
// squared step length, the dot product with the previous motion step, the
// squared distance from the anchor and the squared minimum swing, then ages
// out old reversals from the timestamp store one entry at a time, each with
// a read step and a check step. A clear goes straight to the output step; a
// sample that is no motion or the first motion skips the dot product, and
// one whose dot product is not negative skips the swing check. The age-out
// ends with a final window check when the store is not empty. These steps
// share the one multiply-accumulate unit and the single read port of the
// store. The next input word is taken the cycle after the output step, even
// while the previous result still waits on the output register; a result
// that finds the output register still full holds the sequencer in its
// output step until the old word is taken.
// The timestamp store needs no clearing after reset. Configuration writes are
// to be made only while no word is in flight.
module pointer_shake_detector #(
    parameter int REV_DEPTH = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,

    // input channel
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [103:0]  s_tdata,   // time_us, pos_x, pos_y, step_x, step_y, zero pad
    input  wire logic [0:0]    s_tuser,   // kind

    // result channel
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [7:0]         m_tdata,   // shake, recent_count, zero pad

    // configuration write channel
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [psd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [23:0]   cfg_data
);
    import psd_pkg::*;

    localparam int AW = $clog2(REV_DEPTH);
    localparam int CW = $clog2(REV_DEPTH + 1);
    localparam int SW = CW + 1;

    // configuration registers
    logic [WIN_W-1:0]   window_us_reg;
    logic [SWING_W-1:0] min_swing_reg;
    logic [THR_W-1:0]   min_rev_reg;

    // sequencer
    seq_state_t state_reg, state_next;

    // latched input word
    logic [TIME_W-1:0]        now_reg;
    logic signed [POS_W-1:0]  px_reg, py_reg;
    logic signed [STEP_W-1:0] sx_reg, sy_reg;
    logic                     clr_item_reg;

    // detector state
    logic                     have_dir_reg;
    logic                     have_anchor_reg;
    logic signed [STEP_W-1:0] last_sx_reg, last_sy_reg;
    logic signed [POS_W-1:0]  anchor_x_reg, anchor_y_reg;
    logic [AW-1:0]            oldest_reg;
    logic [CW-1:0]            cnt_reg;
    logic signed [ACC_W-1:0]  dist_reg;

    // output register
    logic       m_tvalid_reg;
    logic [7:0] m_tdata_reg;

    // datapath
    mac_ctrl_t               mac_ctrl;
    logic signed [OPND_W-1:0] mac_a, mac_b;
    logic signed [ACC_W-1:0] acc;
    logic [TIME_W-1:0]       rd_data;
    logic [TIME_W-1:0]       age;
    logic signed [STEP_W-1:0] ex, ey;

    // control of the current cycle
    logic in_accept;
    logic clr_en;
    logic rec_en;
    logic anchor_en;
    logic step_en;
    logic drop_en;
    logic rd_en;
    logic dist_en;
    logic out_load;

    logic [SW-1:0] wr_sum;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] oldest_inc;
    logic [31:0]   cnt_wide;
    logic [7:0]    result_word;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // offsets from the latched anchor, 17 bits hold any difference of two positions
    assign ex = {px_reg[POS_W-1], px_reg} - {anchor_x_reg[POS_W-1], anchor_x_reg};
    assign ey = {py_reg[POS_W-1], py_reg} - {anchor_y_reg[POS_W-1], anchor_y_reg};

    // wrapping age of the oldest stored reversal
    assign age = now_reg - rd_data;

    // ring slot after the newest entry, and the slot after the oldest
    always_comb begin
        wr_sum = SW'(oldest_reg) + SW'(cnt_reg);
        if (wr_sum >= SW'(REV_DEPTH)) begin
            wr_sum = wr_sum - SW'(REV_DEPTH);
        end
        wr_addr = wr_sum[AW-1:0];
        oldest_inc = (oldest_reg == AW'(REV_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;
    end

    // result word
    always_comb begin
        cnt_wide = 32'(cnt_reg);
        result_word = '0;
        if (!clr_item_reg) begin
            result_word[0]   = (cnt_wide >= 32'(min_rev_reg));
            result_word[4:1] = (cnt_wide > 32'd15) ? 4'hF : cnt_wide[3:0];
        end
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        mac_ctrl   = '0;
        mac_a      = '0;
        mac_b      = '0;
        clr_en     = 1'b0;
        rec_en     = 1'b0;
        anchor_en  = 1'b0;
        step_en    = 1'b0;
        drop_en    = 1'b0;
        rd_en      = 1'b0;
        dist_en    = 1'b0;
        out_load   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (s_tuser[0] == KIND_CLEAR) begin
                        clr_en     = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_SQX;
                    end
                end
            end
            ST_SQX: begin
                mac_ctrl   = '{en: 1'b1, acc_clr: 1'b1};
                mac_a      = OPND_W'(sx_reg);
                mac_b      = OPND_W'(sx_reg);
                state_next = ST_SQY;
            end
            ST_SQY: begin
                mac_ctrl   = '{en: 1'b1, acc_clr: 1'b0};
                mac_a      = OPND_W'(sy_reg);
                mac_b      = OPND_W'(sy_reg);
                state_next = ST_DOTX;
            end
            ST_DOTX: begin
                // acc holds the squared step length
                if (acc < MOTION_MIN_SQ) begin
                    state_next = ST_PRD;
                end else if (!have_dir_reg) begin
                    step_en    = 1'b1;
                    anchor_en  = !have_anchor_reg;
                    state_next = ST_PRD;
                end else begin
                    mac_ctrl   = '{en: 1'b1, acc_clr: 1'b1};
                    mac_a      = OPND_W'(sx_reg);
                    mac_b      = OPND_W'(last_sx_reg);
                    state_next = ST_DOTY;
                end
            end
            ST_DOTY: begin
                mac_ctrl   = '{en: 1'b1, acc_clr: 1'b0};
                mac_a      = OPND_W'(sy_reg);
                mac_b      = OPND_W'(last_sy_reg);
                state_next = ST_DOTCHK;
            end
            ST_DOTCHK: begin
                // acc holds the dot product with the previous motion step
                if (acc[ACC_W-1]) begin
                    if (!have_anchor_reg) begin
                        rec_en     = 1'b1;
                        anchor_en  = 1'b1;
                        step_en    = 1'b1;
                        state_next = ST_PRD;
                    end else begin
                        mac_ctrl   = '{en: 1'b1, acc_clr: 1'b1};
                        mac_a      = OPND_W'(ex);
                        mac_b      = OPND_W'(ex);
                        state_next = ST_EY;
                    end
                end else begin
                    step_en    = 1'b1;
                    anchor_en  = !have_anchor_reg;
                    state_next = ST_PRD;
                end
            end
            ST_EY: begin
                mac_ctrl   = '{en: 1'b1, acc_clr: 1'b0};
                mac_a      = OPND_W'(ey);
                mac_b      = OPND_W'(ey);
                state_next = ST_NEED;
            end
            ST_NEED: begin
                dist_en    = 1'b1;
                mac_ctrl   = '{en: 1'b1, acc_clr: 1'b1};
                mac_a      = OPND_W'(min_swing_reg);
                mac_b      = OPND_W'(min_swing_reg);
                state_next = ST_SWING;
            end
            ST_SWING: begin
                // acc holds the squared minimum swing
                if (dist_reg >= acc) begin
                    rec_en    = 1'b1;
                    anchor_en = 1'b1;
                end
                step_en    = 1'b1;
                state_next = ST_PRD;
            end
            ST_PRD: begin
                if (cnt_reg == '0) begin
                    state_next = ST_OUT;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_PCHK;
                end
            end
            ST_PCHK: begin
                if (age > TIME_W'(window_us_reg)) begin
                    drop_en    = 1'b1;
                    state_next = ST_PRD;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    psd_mac u_mac (
        .aclk (aclk),
        .ctrl (mac_ctrl),
        .op_a (mac_a),
        .op_b (mac_b),
        .acc  (acc)
    );

    psd_ring #(
        .DEPTH (REV_DEPTH),
        .AW    (AW)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (rec_en),
        .wr_addr ((cnt_reg < CW'(REV_DEPTH)) ? wr_addr : oldest_reg),
        .wr_data (now_reg),
        .rd_en   (rd_en),
        .rd_addr (oldest_reg),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_us_reg <= WINDOW_US_RST;
            min_swing_reg <= MIN_SWING_RST;
            min_rev_reg   <= REV_THRESH_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_WINDOW_US:  window_us_reg <= cfg_data;
                CFG_MIN_SWING:  min_swing_reg <= cfg_data[SWING_W-1:0];
                CFG_REV_THRESH: min_rev_reg   <= cfg_data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // latched input word, no reset needed
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            now_reg      <= s_tdata[31:0];
            px_reg       <= s_tdata[47:32];
            py_reg       <= s_tdata[63:48];
            sx_reg       <= s_tdata[80:64];
            sy_reg       <= s_tdata[97:81];
            clr_item_reg <= (s_tuser[0] == KIND_CLEAR);
        end
        if (dist_en) begin
            dist_reg <= acc;
        end
    end

    // sequencer, detector state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            have_dir_reg    <= 1'b0;
            have_anchor_reg <= 1'b0;
            last_sx_reg     <= '0;
            last_sy_reg     <= '0;
            anchor_x_reg    <= '0;
            anchor_y_reg    <= '0;
            oldest_reg      <= '0;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (clr_en) begin
                have_dir_reg    <= 1'b0;
                have_anchor_reg <= 1'b0;
                last_sx_reg     <= '0;
                last_sy_reg     <= '0;
                anchor_x_reg    <= '0;
                anchor_y_reg    <= '0;
                oldest_reg      <= '0;
                cnt_reg         <= '0;
            end else begin
                if (step_en) begin
                    last_sx_reg  <= sx_reg;
                    last_sy_reg  <= sy_reg;
                    have_dir_reg <= 1'b1;
                end
                if (anchor_en) begin
                    anchor_x_reg    <= px_reg;
                    anchor_y_reg    <= py_reg;
                    have_anchor_reg <= 1'b1;
                end
                // a full store drops its oldest entry when a new one comes in
                if (rec_en) begin
                    if (cnt_reg < CW'(REV_DEPTH)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end else begin
                        oldest_reg <= oldest_inc;
                    end
                end
                if (drop_en) begin
                    oldest_reg <= oldest_inc;
                    cnt_reg    <= cnt_reg - 1'b1;
                end
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= result_word;
        end
    end

    // store never holds more than its depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CW'(REV_DEPTH))
        else $error("reversal count above store depth");

    // a new result appears only after the sequencer's output step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result word without output step");

    // a clear word empties the store and drops the anchor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser[0] == KIND_CLEAR) |=> (cnt_reg == '0 && !have_anchor_reg))
        else $error("clear word left detector state behind");

    // a sample never finishes before the motion test
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_tuser[0] == KIND_SAMPLE) |=> (state_reg == ST_SQX))
        else $error("sample skipped the step length test");

endmodule

`default_nettype wire

// ----- verif/psd_checker.sv -----
// checker that predicts and compares the result words of the pointer shake detector
`timescale 1ns / 1ps

module psd_checker #(
    parameter int REV_DEPTH = 8
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tready,
    input  wire logic [103:0]  s_tdata,   // time_us, pos_x, pos_y, step_x, step_y, zero pad
    input  wire logic [0:0]    s_tuser,   // kind
    input  wire logic          m_tvalid,
    input  wire logic          m_tready,
    input  wire logic [7:0]    m_tdata,   // shake, recent_count, zero pad
    input  wire logic          cfg_valid,
    input  wire logic          cfg_ready,
    input  wire logic [psd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [23:0]   cfg_data,
    output int                 mismatches,
    output int                 outstanding
);
    import psd_pkg::*;

    typedef struct packed {
        logic       shake;
        logic [3:0] recent;
    } flag_word_t;

    // register copies
    logic [WIN_W-1:0]   window_us;
    logic [SWING_W-1:0] min_swing;
    logic [THR_W-1:0]   rev_thresh;

    // detector state copies
    logic                     have_dir;
    logic                     have_anchor;
    logic signed [STEP_W-1:0] prev_sx;
    logic signed [STEP_W-1:0] prev_sy;
    logic signed [POS_W-1:0]  anchor_x;
    logic signed [POS_W-1:0]  anchor_y;
    logic [TIME_W-1:0]        rev_stamp [REV_DEPTH];
    int                       oldest;
    int                       stored;

    flag_word_t flag_queue [$];

    task automatic clear_tracker();
        have_dir    = 1'b0;
        have_anchor = 1'b0;
        prev_sx     = '0;
        prev_sy     = '0;
        anchor_x    = '0;
        anchor_y    = '0;
        oldest      = 0;
        stored      = 0;
    endtask

    // advance the tracker by one input word and give the flags it yields
    task automatic predict_flags(input logic kind, input logic [103:0] word,
                                 output flag_word_t res);
        logic [TIME_W-1:0]        now;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [STEP_W-1:0] sx;
        logic signed [STEP_W-1:0] sy;
        logic [TIME_W-1:0]        age;
        longint                   ex;
        longint                   ey;
        longint                   need;
        now = word[31:0];
        px  = word[47:32];
        py  = word[63:48];
        sx  = word[80:64];
        sy  = word[97:81];
        if (kind == KIND_CLEAR) begin
            clear_tracker();
            res = '0;
        end else begin
            if (longint'(sx) * longint'(sx) + longint'(sy) * longint'(sy) >= 4) begin
                if (have_dir &&
                    (longint'(sx) * longint'(prev_sx) + longint'(sy) * longint'(prev_sy)) < 0) begin
                    ex   = longint'(px) - longint'(anchor_x);
                    ey   = longint'(py) - longint'(anchor_y);
                    need = longint'(min_swing) * longint'(min_swing);
                    if (!have_anchor || ex * ex + ey * ey >= need) begin
                        // full store: newest overwrites the oldest entry
                        if (stored < REV_DEPTH) begin
                            rev_stamp[(oldest + stored) % REV_DEPTH] = now;
                            stored++;
                        end else begin
                            rev_stamp[oldest] = now;
                            oldest = (oldest + 1) % REV_DEPTH;
                        end
                        anchor_x    = px;
                        anchor_y    = py;
                        have_anchor = 1'b1;
                    end
                end else if (!have_anchor) begin
                    anchor_x    = px;
                    anchor_y    = py;
                    have_anchor = 1'b1;
                end
                prev_sx  = sx;
                prev_sy  = sy;
                have_dir = 1'b1;
            end
            // age out, oldest first, with wrapping time
            while (stored > 0) begin
                age = now - rev_stamp[oldest];
                if (age <= {8'd0, window_us}) break;
                oldest = (oldest + 1) % REV_DEPTH;
                stored--;
            end
            res.shake  = (stored >= int'(rev_thresh));
            res.recent = (stored > 15) ? 4'd15 : 4'(stored);
        end
    endtask

    always @(posedge aclk) begin
        flag_word_t want;
        flag_word_t got;
        if (!aresetn) begin
            window_us  = WINDOW_US_RST;
            min_swing  = MIN_SWING_RST;
            rev_thresh = REV_THRESH_RST;
            clear_tracker();
            flag_queue.delete();
            mismatches  = 0;
            outstanding = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW_US:  window_us  = cfg_data[WIN_W-1:0];
                    CFG_MIN_SWING:  min_swing  = cfg_data[SWING_W-1:0];
                    CFG_REV_THRESH: rev_thresh = cfg_data[THR_W-1:0];
                    default: ;
                endcase
            end
            // results first: a word taken this edge cannot be answered at it
            if (m_tvalid && m_tready) begin
                got.shake  = m_tdata[0];
                got.recent = m_tdata[4:1];
                if (flag_queue.size() == 0) begin
                    $display("%0t: result word with nothing expected, got shake %0d count %0d",
                             $time, got.shake, got.recent);
                    mismatches++;
                end else begin
                    want = flag_queue[0];
                    flag_queue.delete(0);
                    if (got.shake !== want.shake) begin
                        $display("%0t: shake mismatch, expected %0d, actual %0d",
                                 $time, want.shake, got.shake);
                        mismatches++;
                    end
                    if (got.recent !== want.recent) begin
                        $display("%0t: recent_count mismatch, expected %0d, actual %0d",
                                 $time, want.recent, got.recent);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predict_flags(s_tuser[0], s_tdata, want);
                flag_queue = {flag_queue, want};
            end
            outstanding = flag_queue.size();
        end
    end

endmodule

// ----- verif/tb_pointer_shake_detector.sv -----
// top of the pointer shake detector bench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_pointer_shake_detector;
    import psd_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASE_WORDS = 200;
    localparam int TAIL_CYCLES = 40;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [103:0]         s_tdata   = '0;   // time_us, pos_x, pos_y, step_x, step_y, zero pad
    logic [0:0]           s_tuser   = '0;   // kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;          // shake, recent_count, zero pad
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [23:0]          cfg_data  = '0;

    int mismatches;
    int outstanding;

    // words waiting for the feeder: {kind, tdata}
    logic [104:0] stim_q [$];
    int           words_queued = 0;
    int           words_sent   = 0;

    // pointer motion used to build shake strokes
    logic [31:0] clock_us;
    int          cur_x;
    int          cur_y;
    int          dir_x = 1;
    int          dir_y = 0;
    int          speed = 10;
    int          stroke_left = 0;

    int cycle_count = 0;
    int ready_mode  = 0;
    int ready_phase = 0;

    pointer_shake_detector u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psd_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 aclk = ~aclk;

    // hard stop in case the block hangs
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver stalls: modes from always ready to mostly stalled, each held a while
    always @(negedge aclk) begin
        if (ready_phase == 0) begin
            ready_mode  <= $urandom_range(3);
            ready_phase <= $urandom_range(200, 16);
        end else begin
            ready_phase <= ready_phase - 1;
        end
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(3) != 0);
            2:       m_tready <= (ready_phase % 3 == 0);
            default: m_tready <= ($urandom_range(7) == 0);
        endcase
    end

    // feeder: bursts of back-to-back words with random gaps between them;
    // s_tvalid gets at most one assignment per falling edge
    initial begin : feeder
        logic [104:0] w;
        int burst_left;
        int hold;
        burst_left = 0;
        hold = 0;
        @(negedge aclk);
        forever begin
            if (stim_q.size() == 0 || hold > 0) begin
                s_tvalid <= 1'b0;
                if (hold > 0) hold--;
                @(negedge aclk);
            end else begin
                w = stim_q[0];
                stim_q.delete(0);
                s_tuser  <= w[104];
                s_tdata  <= w[103:0];
                s_tvalid <= 1'b1;
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                words_sent++;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    // long bursts now and then give stretches without gaps
                    burst_left = ($urandom_range(4) == 0) ? $urandom_range(80, 20)
                                                          : $urandom_range(8);
                    case ($urandom_range(9))
                        0, 1, 2, 3: hold = 0;
                        4, 5, 6:    hold = $urandom_range(3, 1);
                        7, 8:       hold = $urandom_range(12, 4);
                        default:    hold = $urandom_range(30, 13);
                    endcase
                end
                @(negedge aclk);
            end
        end
    end

    function automatic int pick_signed(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // append one word to the feeder's list
    task automatic add_word(input logic [104:0] w);
        stim_q = {stim_q, w};
        words_queued++;
    endtask

    task automatic queue_sample(input logic [31:0] stamp, input int px, input int py,
                                input int sx, input int sy);
        add_word({KIND_SAMPLE, 6'd0, 17'(sy), 17'(sx), 16'(py), 16'(px), stamp});
    endtask

    // clear word with junk in the other fields
    task automatic queue_clear();
        add_word({KIND_CLEAR, 6'd0, 17'($urandom), 17'($urandom),
                  16'($urandom), 16'($urandom), 32'($urandom)});
    endtask

    // sender holds off until every word is taken and answered
    task automatic wait_idle();
        while (words_sent != words_queued || outstanding != 0) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic apply_settings(input logic [23:0] window, input logic [11:0] swing,
                                  input logic [3:0] threshold);
        write_reg(CFG_WINDOW_US, window);
        write_reg(CFG_MIN_SWING, {12'd0, swing});
        write_reg(CFG_REV_THRESH, {20'd0, threshold});
    endtask

    task automatic pick_direction();
        dir_x = $urandom_range(8) - 4;
        dir_y = $urandom_range(8) - 4;
        if (dir_x == 0 && dir_y == 0) dir_x = 1;
    endtask

    task automatic directed_words();
        // no motion: zero step, then squared length just under the motion limit
        queue_sample(32'd0, 0, 0, 0, 0);
        queue_sample(32'd1, 0, 0, 1, 1);
        // first motion at exactly the limit sets the anchor
        queue_sample(32'd2, 0, 0, 2, 0);
        // reversal far from anchor is recorded
        queue_sample(32'd3, -32768, 0, -2, 0);
        // reversal too close to the anchor is not
        queue_sample(32'd4, -32758, 0, 2, 0);
        // largest steps and positions
        queue_sample(32'd5, 32767, 32767, 65535, -65535);
        queue_sample(32'd6, -32768, -32768, -65535, 65535);
        add_word({KIND_CLEAR, 6'd0, {98{1'b1}}});
        // reversals around the time wrap
        queue_sample(32'hFFFF_FFF0, 0, 0, 0, 3);
        queue_sample(32'hFFFF_FFF8, 0, 100, 0, -3);
        queue_sample(32'h0000_0010, 0, 0, 0, 3);
        // age equal to the window stays, one past it leaves
        queue_sample(32'd599992, 0, 0, 0, 0);
        queue_sample(32'd599993, 0, 0, 0, 0);
        // perpendicular step, then swings of exactly min_swing overflow the store
        queue_sample(32'd600000, 0, 0, 3, 0);
        for (int i = 1; i <= 10; i++)
            queue_sample(32'd600000 + i, (i % 2) ? 30 : 0, 0, (i % 2) ? -3 : 3, 0);
    endtask

    task automatic queue_mixed(input int count);
        int sx;
        int sy;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(99))
                0, 1: queue_clear();
                2, 3, 4, 5, 6, 7, 8, 9, 10, 11:
                    queue_sample($urandom(), pick_signed(-32768, 32767),
                                 pick_signed(-32768, 32767), pick_signed(-65535, 65535),
                                 pick_signed(-65535, 65535));
                default: begin
                    // back and forth strokes along one direction
                    if (stroke_left == 0) begin
                        dir_x = -dir_x;
                        dir_y = -dir_y;
                        if ($urandom_range(9) == 0) pick_direction();
                        stroke_left = $urandom_range(4, 1);
                        speed = ($urandom_range(7) == 0) ? $urandom_range(16000, 300)
                                                         : $urandom_range(60, 1);
                    end
                    stroke_left--;
                    if ($urandom_range(15) == 0) begin
                        // tremor below the motion limit
                        sx = $urandom_range(2) - 1;
                        sy = $urandom_range(2) - 1;
                    end else begin
                        sx = dir_x * speed;
                        sy = dir_y * speed;
                        if ($urandom_range(3) == 0) begin
                            sx += $urandom_range(6) - 3;
                            sy += $urandom_range(6) - 3;
                        end
                    end
                    case ($urandom_range(19))
                        0:       clock_us += 0;
                        1:       clock_us += $urandom_range(2000000, 200000);
                        default: clock_us += $urandom_range(40000, 4000);
                    endcase
                    cur_x += sx;
                    cur_y += sy;
                    if (cur_x > 32767) cur_x -= 65536;
                    if (cur_x < -32768) cur_x += 65536;
                    if (cur_y > 32767) cur_y -= 65536;
                    if (cur_y < -32768) cur_y += 65536;
                    queue_sample(clock_us, cur_x, cur_y, sx, sy);
                end
            endcase
        end
    endtask

    task automatic run_phase(input int count);
        // start near the time wrap now and then
        clock_us = ($urandom_range(2) == 0) ? 32'hFFFF_FFFF - $urandom_range(3000000)
                                            : $urandom();
        cur_x = pick_signed(-2000, 2000);
        cur_y = pick_signed(-2000, 2000);
        pick_direction();
        stroke_left = 0;
        queue_mixed(count);
        wait_idle();
    endtask

    initial begin : stimulus
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // register reset values first
        directed_words();
        wait_idle();

        // widest window, no swing needed, shake always on
        apply_settings(24'hFF_FFFF, 12'd0, 4'd0);
        run_phase(PHASE_WORDS);
        // no window, widest swing, threshold beyond the store
        apply_settings(24'd0, 12'd4095, 4'd15);
        run_phase(PHASE_WORDS);
        apply_settings(24'd600000, 12'd30, 4'd4);
        run_phase(PHASE_WORDS);
        apply_settings(24'd120000, 12'd12, 4'd2);
        run_phase(PHASE_WORDS);
        apply_settings(24'($urandom_range(1500000, 20000)), 12'($urandom_range(80)),
                       4'($urandom_range(8, 1)));
        run_phase(PHASE_WORDS);
        apply_settings(24'($urandom()), 12'($urandom()), 4'($urandom()));
        run_phase(PHASE_WORDS);

        // let any stray result words show up
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- pointer_shake_detector.f -----
hdl/psd_pkg.sv
hdl/psd_mac.sv
hdl/psd_ring.sv
hdl/pointer_shake_detector.sv
verif/psd_checker.sv
verif/tb_pointer_shake_detector.sv
